// ===== src/ptsch_pkg.sv =====
// Shared sizes, entry codes and cell-chain structures of the process table scheduler.
package ptsch_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = 4;
    localparam int PID_W    = 8;
    localparam int WAIT_W   = 16;
    localparam logic [PID_W-1:0]  PID_MAX  = 8'd255;
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_SPAWNED = 2'd1,
        ST_WAITING = 2'd2,
        ST_ACTIVE  = 2'd3
    } t_est;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SPAWN  = 3'd1,
        OP_KILL   = 3'd2,
        OP_AGE    = 3'd3,
        OP_CHOOSE = 3'd4
    } t_op;

    // Command broadcast by the controller to every cell.
    typedef struct packed {
        t_op               op;
        logic [PID_W-1:0]  id;
        logic [SLOT_W-1:0] slot;
        logic              clr_wait;
        logic              activate;
        logic              demote;
        logic [PID_W-1:0]  old_id;
    } t_cmd;

    // First-match lookups rippled from cell to cell.
    typedef struct packed {
        logic              free_f;
        logic [SLOT_W-1:0] free_idx;
        logic              hit_f;
        logic [SLOT_W-1:0] hit_idx;
        logic              bs_f;
        logic [SLOT_W-1:0] bs_idx;
    } t_link;

    // Longest-wait token, registered in each cell as it travels down the row.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] best_idx;
        logic [PID_W-1:0]  best_id;
        logic [WAIT_W-1:0] best_wait;
    } t_tok;

endpackage

// ===== src/ptsch_cell.sv =====
// One table entry: status, ID and wait counter, with its links to the neighbor cells.
module ptsch_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ptsch_pkg::SLOT_W-1:0] i_index,
    input  ptsch_pkg::t_cmd            i_cmd,
    input  ptsch_pkg::t_link           i_link,
    output ptsch_pkg::t_link           o_link,
    input  ptsch_pkg::t_tok            i_tok,
    output ptsch_pkg::t_tok            o_tok
);

    ptsch_pkg::t_est                 r_status;
    logic [ptsch_pkg::PID_W-1:0]     r_id;
    logic [ptsch_pkg::WAIT_W-1:0]    r_wait;
    ptsch_pkg::t_tok                 r_tok;

    logic w_live;
    logic w_free;
    logic w_hit;
    logic w_bs;
    logic w_better;

    assign w_live   = (r_status != ptsch_pkg::ST_STOPPED);
    assign w_free   = !w_live;
    assign w_hit    = w_live && (r_id == i_cmd.id);
    assign w_bs     = w_live && (r_id == '0);
    assign w_better = w_live && (r_id != '0) && (r_wait > i_tok.best_wait);

    always_comb begin
        o_link.free_f   = i_link.free_f | w_free;
        o_link.free_idx = i_link.free_f ? i_link.free_idx : i_index;
        o_link.hit_f    = i_link.hit_f | w_hit;
        o_link.hit_idx  = i_link.hit_f ? i_link.hit_idx : i_index;
        o_link.bs_f     = i_link.bs_f | w_bs;
        o_link.bs_idx   = i_link.bs_f ? i_link.bs_idx : i_index;
    end

    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= ptsch_pkg::ST_STOPPED;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            if (w_better) begin
                r_tok.best_idx  <= i_index;
                r_tok.best_id   <= r_id;
                r_tok.best_wait <= r_wait;
            end else begin
                r_tok.best_idx  <= i_tok.best_idx;
                r_tok.best_id   <= i_tok.best_id;
                r_tok.best_wait <= i_tok.best_wait;
            end
            case (i_cmd.op)
                ptsch_pkg::OP_SPAWN: begin
                    if (w_free && !i_link.free_f) begin
                        r_status <= ptsch_pkg::ST_SPAWNED;
                        r_id     <= i_cmd.id;
                        r_wait   <= '0;
                    end
                end
                ptsch_pkg::OP_KILL: begin
                    if (i_index == i_cmd.slot) begin
                        r_status <= ptsch_pkg::ST_STOPPED;
                    end
                end
                ptsch_pkg::OP_AGE: begin
                    if (w_live && (r_id != '0) && (r_wait != ptsch_pkg::WAIT_MAX)) begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                ptsch_pkg::OP_CHOOSE: begin
                    if (i_index == i_cmd.slot) begin
                        if (i_cmd.clr_wait) begin
                            r_wait <= '0;
                        end
                        if (i_cmd.activate) begin
                            r_status <= ptsch_pkg::ST_ACTIVE;
                        end
                    end else if (i_cmd.demote && w_live && (r_id == i_cmd.old_id)
                                 && (r_status == ptsch_pkg::ST_ACTIVE)) begin
                        r_status <= ptsch_pkg::ST_WAITING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/process_table_scheduler.sv =====
// Top level: request controller over a row of process table cells.
// A failed lookup, a full table or a switch to the active process goes straight to the
// output word; a switch, a kill and a failed tick first pass their own state. A spawn
// skips live IDs and reports a full table when every ID is taken; a tick ages the entries
// and walks a token down the row one cell per cycle, also after killing the active process.
// One word at a time; reset stops every entry and clears the active process and ID state.
module process_table_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_target_pid,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_result_pid,
    output logic [3:0]  o_slot,
    output logic        o_switched,
    output logic [7:0]  o_active_pid,
    output logic        o_active_valid
);

    // Request codes of the input word.
    localparam logic [1:0] FN_SPAWN  = 2'd0;
    localparam logic [1:0] FN_KILL   = 2'd1;
    localparam logic [1:0] FN_TICK   = 2'd2;
    localparam logic [1:0] FN_SWITCH = 2'd3;

    // Status codes of the output word.
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_FULL     = 2'd1;
    localparam logic [1:0] RS_NOTFOUND = 2'd2;
    localparam logic [1:0] RS_NORUN    = 2'd3;

    localparam int SLOTS  = ptsch_pkg::SLOTS;
    localparam int SLOT_W = ptsch_pkg::SLOT_W;
    localparam int PID_W  = ptsch_pkg::PID_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SP_SEARCH,
        S_SP_WRITE,
        S_KILL,
        S_SWITCH,
        S_TK_CHECK,
        S_TK_AGE,
        S_TK_INJ,
        S_TK_WAIT,
        S_TK_CHOOSE,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [PID_W-1:0]    r_target;
    logic [PID_W-1:0]    r_cand;
    logic [PID_W-1:0]    r_tries;
    logic [PID_W-1:0]    r_last;
    logic                r_any;
    logic [PID_W-1:0]    r_cur;
    logic                r_cur_v;
    logic                r_from_kill;
    logic [SLOT_W-1:0]   r_best_idx;
    logic [PID_W-1:0]    r_best_id;
    logic [1:0]          r_res_status;
    logic [PID_W-1:0]    r_res_pid;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_res_sw;

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [PID_W-1:0]    r_o_pid;
    logic [SLOT_W-1:0]   r_o_slot;
    logic                r_o_sw;
    logic [PID_W-1:0]    r_o_act;
    logic                r_o_act_v;

    ptsch_pkg::t_cmd     w_cmd;
    ptsch_pkg::t_link    w_link [SLOTS+1];
    ptsch_pkg::t_tok     w_tok  [SLOTS+1];
    logic [PID_W-1:0]    w_next_cand;
    logic                w_accept;
    logic                w_sw_tick;
    logic                w_out_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_next_cand = (r_cand >= ptsch_pkg::PID_MAX) ? PID_W'(1) : r_cand + 1'b1;
    assign w_sw_tick   = !r_cur_v || (r_best_id != r_cur);
    assign w_out_free  = !r_o_valid || !i_out_stall;

    // Command broadcast to the cell row for the current step.
    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = ptsch_pkg::OP_NONE;
        w_cmd.id       = i_target_pid;
        w_cmd.old_id   = r_cur;
        w_cmd.demote   = r_cur_v;
        case (r_state)
            S_SP_SEARCH: begin
                w_cmd.id = w_next_cand;
            end
            S_SP_WRITE: begin
                w_cmd.op = ptsch_pkg::OP_SPAWN;
                w_cmd.id = r_cand;
            end
            S_KILL: begin
                w_cmd.op   = ptsch_pkg::OP_KILL;
                w_cmd.slot = r_res_slot;
            end
            S_SWITCH: begin
                w_cmd.op       = ptsch_pkg::OP_CHOOSE;
                w_cmd.slot     = r_best_idx;
                w_cmd.activate = 1'b1;
            end
            S_TK_AGE: begin
                w_cmd.op = ptsch_pkg::OP_AGE;
            end
            S_TK_CHOOSE: begin
                w_cmd.op       = ptsch_pkg::OP_CHOOSE;
                w_cmd.slot     = r_best_idx;
                w_cmd.clr_wait = 1'b1;
                w_cmd.activate = w_sw_tick;
            end
            default: begin
            end
        endcase
    end

    // The token enters at the head of the row with the backstop as the standing choice.
    assign w_link[0] = '0;
    assign w_tok[0]  = '{valid:     (r_state == S_TK_INJ),
                         best_idx:  w_link[SLOTS].bs_idx,
                         best_id:   '0,
                         best_wait: '0};

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ptsch_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLOT_W'(g)),
            .i_cmd   (w_cmd),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_any       <= 1'b0;
            r_last      <= '0;
            r_cur       <= '0;
            r_cur_v     <= 1'b0;
            r_from_kill <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            // The final state loads the next word itself when the output is taken.
            if (r_o_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_target     <= i_target_pid;
                        r_res_status <= RS_OK;
                        r_res_pid    <= i_target_pid;
                        r_res_slot   <= '0;
                        r_res_sw     <= 1'b0;
                        r_from_kill  <= 1'b0;
                        case (i_func)
                            FN_SPAWN: begin
                                r_res_pid <= '0;
                                r_tries   <= '0;
                                if (!w_link[SLOTS].free_f) begin
                                    r_res_status <= RS_FULL;
                                    r_state      <= S_FIN;
                                end else if (!r_any) begin
                                    r_cand  <= '0;
                                    r_state <= S_SP_WRITE;
                                end else begin
                                    r_cand  <= r_last;
                                    r_state <= S_SP_SEARCH;
                                end
                            end
                            FN_KILL: begin
                                if (!w_link[SLOTS].hit_f) begin
                                    r_res_status <= RS_NOTFOUND;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_res_slot <= w_link[SLOTS].hit_idx;
                                    r_state    <= S_KILL;
                                end
                            end
                            FN_TICK: begin
                                r_res_pid <= '0;
                                r_state   <= S_TK_CHECK;
                            end
                            FN_SWITCH: begin
                                if (!w_link[SLOTS].hit_f) begin
                                    r_res_status <= RS_NOTFOUND;
                                    r_state      <= S_FIN;
                                end else if (r_cur_v && (r_cur == i_target_pid)) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_best_idx <= w_link[SLOTS].hit_idx;
                                    r_state    <= S_SWITCH;
                                end
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SP_SEARCH: begin
                    r_cand <= w_next_cand;
                    if (!w_link[SLOTS].hit_f) begin
                        r_state <= S_SP_WRITE;
                    end else if (r_tries == ptsch_pkg::PID_MAX - 1'b1) begin
                        r_res_status <= RS_FULL;
                        r_state      <= S_FIN;
                    end else begin
                        r_tries <= r_tries + 1'b1;
                    end
                end
                S_SP_WRITE: begin
                    r_res_slot <= w_link[SLOTS].free_idx;
                    r_res_pid  <= r_cand;
                    r_last     <= r_cand;
                    r_any      <= 1'b1;
                    r_state    <= S_FIN;
                end
                S_KILL: begin
                    if (r_cur_v && (r_cur == r_target)) begin
                        r_cur       <= '0;
                        r_cur_v     <= 1'b0;
                        r_from_kill <= 1'b1;
                        r_state     <= S_TK_CHECK;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SWITCH: begin
                    r_cur    <= r_target;
                    r_cur_v  <= 1'b1;
                    r_res_sw <= 1'b1;
                    r_state  <= S_FIN;
                end
                S_TK_CHECK: begin
                    // Without a live backstop the tick leaves every entry untouched.
                    if (!w_link[SLOTS].bs_f) begin
                        r_res_status <= RS_NORUN;
                        r_state      <= S_FIN;
                    end else begin
                        r_state <= S_TK_AGE;
                    end
                end
                S_TK_AGE: begin
                    r_state <= S_TK_INJ;
                end
                S_TK_INJ: begin
                    r_state <= S_TK_WAIT;
                end
                S_TK_WAIT: begin
                    if (w_tok[SLOTS].valid) begin
                        r_best_idx <= w_tok[SLOTS].best_idx;
                        r_best_id  <= w_tok[SLOTS].best_id;
                        r_state    <= S_TK_CHOOSE;
                    end
                end
                S_TK_CHOOSE: begin
                    if (w_sw_tick) begin
                        r_cur    <= r_best_id;
                        r_cur_v  <= 1'b1;
                        r_res_sw <= 1'b1;
                    end
                    // A kill keeps reporting the killed ID and its released slot.
                    if (!r_from_kill) begin
                        r_res_pid  <= r_best_id;
                        r_res_slot <= r_best_idx;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_pid    <= r_res_pid;
                        r_o_slot   <= r_res_slot;
                        r_o_sw     <= r_res_sw;
                        r_o_act    <= r_cur_v ? r_cur : '0;
                        r_o_act_v  <= r_cur_v;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_pid   = r_o_pid;
    assign o_slot         = r_o_slot;
    assign o_switched     = r_o_sw;
    assign o_active_pid   = r_o_act;
    assign o_active_valid = r_o_act_v;

    // A word just taken keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // With no active process the reported active ID is zero.
    a_idle_pid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active_valid) |-> (o_active_pid == '0))
        else $error("active ID nonzero while none is active");

    // A full table reports neither an ID nor a slot.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == RS_FULL)) |-> ((o_result_pid == '0) && (o_slot == '0)))
        else $error("table full result carries an ID or slot");

    // A context switch always leaves some process active.
    a_switch_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_switched) |-> o_active_valid)
        else $error("switch reported with no active process");

endmodule

// ===== tb/sv/ptsch_checker.sv =====
`timescale 1ns / 100ps
// Checker of the process table scheduler: shared codes, word predictor and result compare.
package ptsch_tb_pkg;

    localparam logic [1:0] FN_SPAWN  = 2'd0;
    localparam logic [1:0] FN_KILL   = 2'd1;
    localparam logic [1:0] FN_TICK   = 2'd2;
    localparam logic [1:0] FN_SWITCH = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_NO_RUN  = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pid;
        logic [3:0] slot;
        logic       switched;
        logic [7:0] act_pid;
        logic       act_valid;
    } t_word;

endpackage

module ptsch_checker (
    input  logic        i_clk,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_target_pid,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_result_pid,
    input  logic [3:0]  i_slot,
    input  logic        i_switched,
    input  logic [7:0]  i_active_pid,
    input  logic        i_active_valid,
    output int          o_fail_count,
    output int          o_pending
);

    ptsch_pkg::t_est     proc_state [ptsch_pkg::SLOTS];
    logic [7:0]          proc_id    [ptsch_pkg::SLOTS];
    logic [15:0]         proc_wait  [ptsch_pkg::SLOTS];
    logic [7:0]          run_pid    = '0;
    bit                  run_valid  = 1'b0;
    logic [7:0]          last_pid   = '0;
    bit                  issued     = 1'b0;
    ptsch_tb_pkg::t_word expected_words [$];
    int                  fails      = 0;
    int                  pending    = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    initial begin
        for (int i = 0; i < ptsch_pkg::SLOTS; i++) begin
            proc_state[i] = ptsch_pkg::ST_STOPPED;
            proc_id[i]    = '0;
            proc_wait[i]  = '0;
        end
    end

    function automatic int live_slot(logic [7:0] pid);
        for (int i = 0; i < ptsch_pkg::SLOTS; i++)
            if (proc_state[i] != ptsch_pkg::ST_STOPPED && proc_id[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic void promote(int s);
        int prev;
        if (run_valid) begin
            prev = live_slot(run_pid);
            if (prev >= 0 && proc_state[prev] == ptsch_pkg::ST_ACTIVE)
                proc_state[prev] = ptsch_pkg::ST_WAITING;
        end
        proc_state[s] = ptsch_pkg::ST_ACTIVE;
        run_pid       = proc_id[s];
        run_valid     = 1'b1;
    endfunction

    // Ages live entries other than the backstop and picks the longest waiter; -1 when the backstop is gone.
    function automatic int age_and_pick(output bit sw);
        int best;
        sw   = 1'b0;
        best = live_slot(8'd0);
        if (best < 0)
            return -1;
        for (int i = 0; i < ptsch_pkg::SLOTS; i++) begin
            if (proc_state[i] != ptsch_pkg::ST_STOPPED && proc_id[i] != 8'd0) begin
                if (proc_wait[i] < ptsch_pkg::WAIT_MAX)
                    proc_wait[i]++;
                if (proc_wait[i] > proc_wait[best])
                    best = i;
            end
        end
        proc_wait[best] = '0;
        if (!run_valid || proc_id[best] != run_pid) begin
            promote(best);
            sw = 1'b1;
        end
        return best;
    endfunction

    function automatic void predict_word(logic [1:0] fn, logic [7:0] tpid);
        ptsch_tb_pkg::t_word w;
        int         s;
        int         free_s;
        bit         got;
        bit         sw;
        bit         was_run;
        logic [7:0] cand;
        w      = '0;
        w.pid  = tpid;
        sw     = 1'b0;
        case (fn)
            ptsch_tb_pkg::FN_SPAWN: begin
                free_s = -1;
                got    = 1'b0;
                cand   = last_pid;
                w.pid  = '0;
                for (int i = 0; i < ptsch_pkg::SLOTS; i++)
                    if (free_s < 0 && proc_state[i] == ptsch_pkg::ST_STOPPED)
                        free_s = i;
                if (free_s >= 0) begin
                    if (!issued) begin
                        cand = '0;
                        got  = 1'b1;
                    end else begin
                        for (int t = 0; t < ptsch_pkg::PID_MAX && !got; t++) begin
                            cand = (cand >= ptsch_pkg::PID_MAX) ? 8'd1 : cand + 8'd1;
                            if (live_slot(cand) < 0)
                                got = 1'b1;
                        end
                    end
                end
                if (!got) begin
                    w.status = ptsch_tb_pkg::STAT_FULL;
                end else begin
                    issued            = 1'b1;
                    last_pid          = cand;
                    proc_id[free_s]   = cand;
                    proc_state[free_s] = ptsch_pkg::ST_SPAWNED;
                    proc_wait[free_s] = '0;
                    w.pid             = cand;
                    w.slot            = free_s[3:0];
                end
            end
            ptsch_tb_pkg::FN_KILL: begin
                s = live_slot(tpid);
                if (s < 0) begin
                    w.status = ptsch_tb_pkg::STAT_MISSING;
                end else begin
                    was_run       = run_valid && run_pid == tpid;
                    proc_state[s] = ptsch_pkg::ST_STOPPED;
                    w.slot        = s[3:0];
                    if (was_run) begin
                        run_valid = 1'b0;
                        run_pid   = '0;
                        if (age_and_pick(sw) < 0)
                            w.status = ptsch_tb_pkg::STAT_NO_RUN;
                    end
                end
            end
            ptsch_tb_pkg::FN_TICK: begin
                s = age_and_pick(sw);
                if (s < 0) begin
                    w.status = ptsch_tb_pkg::STAT_NO_RUN;
                    w.pid    = '0;
                end else begin
                    w.pid  = proc_id[s];
                    w.slot = s[3:0];
                end
            end
            default: begin
                s = live_slot(tpid);
                if (s < 0) begin
                    w.status = ptsch_tb_pkg::STAT_MISSING;
                end else if (!(run_valid && live_slot(run_pid) == s)) begin
                    promote(s);
                    sw = 1'b1;
                end
            end
        endcase
        w.switched  = sw;
        w.act_pid   = run_valid ? run_pid : 8'd0;
        w.act_valid = run_valid;
        expected_words.push_back(w);
    endfunction

    always @(posedge i_clk) begin
        ptsch_tb_pkg::t_word got_w;
        ptsch_tb_pkg::t_word exp_w;
        if (i_in_valid && !i_in_stall)
            predict_word(i_func, i_target_pid);
        if (i_out_valid && !i_out_stall) begin
            got_w = '{i_status, i_result_pid, i_slot, i_switched, i_active_pid,
                      i_active_valid};
            if (expected_words.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result word %p", got_w);
            end else begin
                exp_w = expected_words.pop_front();
                if (got_w !== exp_w) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected %p, got %p", exp_w, got_w);
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

// ===== tb/sv/tb_process_table_scheduler.sv =====
`timescale 1ns / 100ps
// Top of the process table scheduler testbench: clock, reset, request stimulus and verdict.
module tb_process_table_scheduler;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int RANDOM_WORDS = 1080;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [1:0] i_func         = ptsch_tb_pkg::FN_SPAWN;
    logic [7:0] i_target_pid   = '0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_status;
    logic [7:0] o_result_pid;
    logic [3:0] o_slot;
    logic       o_switched;
    logic [7:0] o_active_pid;
    logic       o_active_valid;
    int         fail_count;
    int         pending;
    int         cycles         = 0;
    // Sender and receiver each flip between bursty and gap-free stretches.
    bit         send_quiet     = 1'b0;
    bit         recv_quiet     = 1'b0;
    bit         long_hold_req  = 1'b0;
    // Rough count of IDs handed out so far, used to aim kills and switches at live IDs.
    int         spawn_words    = 0;

    always #1 i_clk = ~i_clk;

    process_table_scheduler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_target_pid   (i_target_pid),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_pid   (o_result_pid),
        .o_slot         (o_slot),
        .o_switched     (o_switched),
        .o_active_pid   (o_active_pid),
        .o_active_valid (o_active_valid)
    );

    ptsch_checker u_checker (
        .i_clk          (i_clk),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_target_pid   (i_target_pid),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_result_pid   (o_result_pid),
        .i_slot         (o_slot),
        .i_switched     (o_switched),
        .i_active_pid   (o_active_pid),
        .i_active_valid (o_active_valid),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Hard stop in case the block hangs on a handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one request word after a random gap and holds it until the block takes it.
    // Valid stays high across back-to-back words, so it is never lowered and raised
    // within one time step.
    task automatic send_word(logic [1:0] fn, logic [7:0] tpid);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_target_pid <= tpid;
        do @(posedge i_clk); while (o_in_stall);
        if (fn == ptsch_tb_pkg::FN_SPAWN)
            spawn_words++;
    endtask

    // Picks a target near the recently issued IDs most of the time, so that kills and
    // switches mostly hit live processes; the rest spans the whole 8-bit range.
    function automatic logic [7:0] pick_target();
        int back;
        if ($urandom_range(0, 99) < 20)
            return 8'($urandom_range(0, 255));
        back = spawn_words - $urandom_range(0, 24);
        if (back < 1)
            back = 1;
        return 8'(((back - 1) % 255) + 1);
    endfunction

    // Receiver: stalls a random number of cycles before each result word. One long
    // hold-off, requested by the stimulus, lets the block fill up and stall its input.
    initial begin
        int n;
        forever begin
            n = recv_quiet ? 0 : $urandom_range(0, 18);
            if (long_hold_req) begin
                n             = 400;
                long_hold_req = 1'b0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        int  r;
        int  tries;
        logic [1:0] fn;
        logic [7:0] tpid;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: a tick and lookups on an empty table, then the backstop
        // spawn, scheduling, switching (also to the already active process), killing the
        // active process, and spawns until the table is full.
        send_word(ptsch_tb_pkg::FN_TICK,   8'd0);
        send_word(ptsch_tb_pkg::FN_SWITCH, 8'd5);
        send_word(ptsch_tb_pkg::FN_KILL,   8'd7);
        send_word(ptsch_tb_pkg::FN_SPAWN,  8'd0);
        send_word(ptsch_tb_pkg::FN_TICK,   8'd0);
        repeat (3) send_word(ptsch_tb_pkg::FN_SPAWN, 8'hFF);
        send_word(ptsch_tb_pkg::FN_TICK,   8'd0);
        send_word(ptsch_tb_pkg::FN_TICK,   8'd0);
        send_word(ptsch_tb_pkg::FN_SWITCH, 8'd2);
        send_word(ptsch_tb_pkg::FN_SWITCH, 8'd2);
        send_word(ptsch_tb_pkg::FN_KILL,   8'd2);
        send_word(ptsch_tb_pkg::FN_KILL,   8'd255);
        repeat (14) send_word(ptsch_tb_pkg::FN_SPAWN, 8'd0);

        // Random part. Kills never hit ID 0 here: once the backstop is gone it never
        // comes back, and every later tick would fail.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 64 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            if (k == 300)
                long_hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30)
                fn = ptsch_tb_pkg::FN_SPAWN;
            else if (r < 55)
                fn = ptsch_tb_pkg::FN_KILL;
            else if (r < 78)
                fn = ptsch_tb_pkg::FN_TICK;
            else
                fn = ptsch_tb_pkg::FN_SWITCH;
            tpid = pick_target();
            tries = 0;
            while (fn == ptsch_tb_pkg::FN_KILL && tpid == 8'd0 && tries < 8) begin
                tpid = pick_target();
                tries++;
            end
            if (fn == ptsch_tb_pkg::FN_KILL && tpid == 8'd0)
                tpid = 8'd1;
            send_word(fn, tpid);
        end

        // Closing: make the backstop active and kill it, so the rescheduling fails, then
        // tick without a backstop and look it up again.
        send_word(ptsch_tb_pkg::FN_SWITCH, 8'd0);
        send_word(ptsch_tb_pkg::FN_KILL,   8'd0);
        send_word(ptsch_tb_pkg::FN_TICK,   8'd0);
        send_word(ptsch_tb_pkg::FN_SWITCH, 8'd0);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
